@@ src/windowed_near_duplicate_detector_core_assert.svh @@
// ---------------------------------------------------------------------------
// assertion macros for the near-duplicate detector core
// ---------------------------------------------------------------------------
`ifndef WINDOWED_NEAR_DUPLICATE_DETECTOR_CORE_ASSERT_SVH
`define WINDOWED_NEAR_DUPLICATE_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WNDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define WNDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wndd_pkg.sv @@
// ---------------------------------------------------------------------------
// wndd_pkg
// shared constants and types of the near-duplicate detector
// ---------------------------------------------------------------------------
package wndd_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int WIN_IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  localparam int SAMPLE_W   = 32;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int WLEN_W     = 5;
  localparam int TOL_W      = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'b1;

  localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 5'd16;
  localparam logic [TOL_W-1:0]  TOLERANCE_RESET  = '0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic commit;   // compare, shift window and load result
  } ctrl_cmd_t;

endpackage

@@ src/wndd_ctrl.sv @@
// ---------------------------------------------------------------------------
// wndd_ctrl
// two-state sequencer and output valid for the detector
// ---------------------------------------------------------------------------
module wndd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wndd_pkg::ctrl_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // result slot free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q == ST_BUSY);
  assign out_valid_o = out_valid_q;

endmodule

@@ src/wndd_datapath.sv @@
// ---------------------------------------------------------------------------
// wndd_datapath
// window shift chain, parallel tolerance compare, config and result registers
// ---------------------------------------------------------------------------
module wndd_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wndd_pkg::ctrl_cmd_t                  cmd_i,
  input  logic signed [wndd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 list_start_i,
  input  logic                                 cfg_we_i,
  input  logic [wndd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wndd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                 near_hit_o,
  output logic                                 hit_so_far_o
);

  localparam int DIFF_W = wndd_pkg::DIFF_W;

  logic [wndd_pkg::WLEN_W-1:0] win_len_q;
  logic [wndd_pkg::TOL_W-1:0]  tol_q;

  logic signed [wndd_pkg::SAMPLE_W-1:0] smp_q;
  logic                                 start_q;

  logic signed [wndd_pkg::SAMPLE_W-1:0] win_q [wndd_pkg::WINDOW_MAX];
  logic [wndd_pkg::WINDOW_MAX-1:0]      win_vld_q, win_vld_d;
  logic                                 hit_flag_q, hit_flag_d;
  logic                                 near_hit_q, hit_so_far_q;

  logic [wndd_pkg::WINDOW_MAX-1:0]    lane_hit;
  logic signed [wndd_pkg::DIFF_W-1:0] diff  [wndd_pkg::WINDOW_MAX];
  logic [wndd_pkg::DIFF_W-1:0]        mag   [wndd_pkg::WINDOW_MAX];
  logic                               hit;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= wndd_pkg::WINDOW_LEN_RESET;
      tol_q     <= wndd_pkg::TOLERANCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wndd_pkg::REG_WINDOW_LEN: win_len_q <= cfg_data_i[wndd_pkg::WLEN_W-1:0];
        wndd_pkg::REG_TOLERANCE:  tol_q     <= cfg_data_i[wndd_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q   <= sample_i;
      start_q <= list_start_i;
    end
  end

  // one lane per window entry: exact 33-bit difference, magnitude, compare
  always_comb begin
    for (int i = 0; i < wndd_pkg::WINDOW_MAX; i++) begin
      diff[i]     = DIFF_W'(win_q[i]) - DIFF_W'(smp_q);
      mag[i]      = diff[i][wndd_pkg::DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
      lane_hit[i] = win_vld_q[i] && !start_q && (i < int'(win_len_q))
                    && (mag[i] <= {2'b00, tol_q});
    end
    hit = |lane_hit;
  end

  always_comb begin
    win_vld_d = start_q ? '0 : win_vld_q;
    win_vld_d = {win_vld_d[wndd_pkg::WINDOW_MAX-2:0], 1'b1};
    hit_flag_d = (hit_flag_q && !start_q) || hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q  <= '0;
      hit_flag_q <= 1'b0;
    end else if (cmd_i.commit) begin
      win_vld_q  <= win_vld_d;
      hit_flag_q <= hit_flag_d;
    end
  end

  // window values and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      win_q[0] <= smp_q;
      for (int i = 1; i < wndd_pkg::WINDOW_MAX; i++) begin
        win_q[i] <= win_q[i-1];
      end
      near_hit_q   <= hit;
      hit_so_far_q <= hit_flag_d;
    end
  end

  assign near_hit_o   = near_hit_q;
  assign hit_so_far_o = hit_so_far_q;

endmodule

@@ src/windowed_near_duplicate_detector_core.sv @@
// ---------------------------------------------------------------------------
// windowed_near_duplicate_detector_core
// flags words lying within a tolerance of any of the last window_len words
// ---------------------------------------------------------------------------
// input channel: sample_i / list_start_i, taken when in_valid_i is high and
//   in_stall_o is low; list_start_i clears the window and the sticky flag
// output channel: near_hit_o / hit_so_far_o, one result word per input word,
//   taken when out_valid_o is high and out_stall_i is low
// config channel: cfg_index_i selects window_len (0) or tolerance (1),
//   written when cfg_valid_i and cfg_ready_o are high; cfg_ready_o is always
//   high, and writes are meant to land only while the block is idle
// sequence: an accepted word is registered, compared while the controller is
//   busy, and its result is loaded into the result register on commit
// pacing: the capture/compare sequence of the controller takes no new word
//   until the last is committed; all window entries are compared in parallel
// stall: the result register holds while out_stall_i is high; a new word may
//   still be captured, then the compare waits until the result slot frees
// reset: window empty, sticky flag clear, window_len 16, tolerance 0
// ---------------------------------------------------------------------------
`include "windowed_near_duplicate_detector_core_assert.svh"

module windowed_near_duplicate_detector_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input word
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [wndd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 list_start_i,
  // result word
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 near_hit_o,
  output logic                                 hit_so_far_o,
  // config writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wndd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wndd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  wndd_pkg::ctrl_cmd_t cmd;
  logic                cfg_we;

  // config registers never back-pressure
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencer: idle -> busy on capture, busy -> idle on commit
  wndd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // window chain, compare lanes and result payload
  wndd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_i     (sample_i),
    .list_start_i (list_start_i),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .near_hit_o   (near_hit_o),
    .hit_so_far_o (hit_so_far_o)
  );

  // an accepted word always occupies the compare cycle
  `WNDD_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o, "no busy cycle after accept")
  // a fresh result only follows a compare cycle
  `WNDD_ASSERT_NOW(a_result_after_busy, $rose(out_valid_o), $past(in_stall_o), "result without compare")
  // a near hit always sets the sticky flag
  `WNDD_ASSERT_NOW(a_hit_sticky, out_valid_o && near_hit_o, hit_so_far_o, "near hit without sticky flag")

endmodule
